[design/assert_macros.svh]
// assertion helpers shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication into the next cycle, ignored while in reset
`define VCRD_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

// same-cycle implication, ignored while in reset
`define VCRD_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// implication into the next cycle, checked during reset too
`define VCRD_ASSERT_RST(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) (pre) |=> (post)) else $error(msg);

`endif

[design/vcrd_pkg.sv]
package vcrd_pkg;

    // default sizes
    localparam int MAX_THREADS_DEF    = 8;
    localparam int LOCK_ENTRIES_DEF   = 16;
    localparam int ACCESS_ENTRIES_DEF = 256;
    localparam int CLOCK_BITS_DEF     = 32;
    localparam int TAG_BITS           = 64;

    // event kinds
    localparam logic [2:0] KIND_START   = 3'd0;
    localparam logic [2:0] KIND_ACQUIRE = 3'd1;
    localparam logic [2:0] KIND_RELEASE = 3'd2;
    localparam logic [2:0] KIND_READ    = 3'd3;
    localparam logic [2:0] KIND_WRITE   = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SEARCH,
        ST_VEC,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        OP_START,
        OP_ACQ,
        OP_REL,
        OP_RD,
        OP_WR,
        OP_RD_NEW,
        OP_WR_NEW
    } t_op;

    // control from the sequencer to the tag search unit
    typedef struct packed {
        logic start;
        logic is_lock;
        logic alloc;
    } t_srch_ctl;

    // status back from the tag search unit
    typedef struct packed {
        logic done;
        logic hit;
        logic full;
    } t_srch_sts;

endpackage

[design/vcrd_ram.sv]
module vcrd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/vcrd_search.sv]
module vcrd_search #(
    parameter int LOCK_ENTRIES   = vcrd_pkg::LOCK_ENTRIES_DEF,
    parameter int ACCESS_ENTRIES = vcrd_pkg::ACCESS_ENTRIES_DEF,
    parameter int SW             = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  vcrd_pkg::t_srch_ctl           i_ctl,
    input  logic [vcrd_pkg::TAG_BITS-1:0] i_tag,
    output vcrd_pkg::t_srch_sts           o_sts,
    output logic [SW-1:0]                 o_slot
);

    localparam int LAW = (LOCK_ENTRIES > 1) ? $clog2(LOCK_ENTRIES) : 1;
    localparam int AAW = $clog2(ACCESS_ENTRIES);
    localparam int LCW = $clog2(LOCK_ENTRIES + 1);
    localparam int ACW = $clog2(ACCESS_ENTRIES + 1);
    localparam int CW  = (LCW > ACW) ? LCW : ACW;

    logic [LCW-1:0] r_lcnt;
    logic [ACW-1:0] r_acnt;
    logic [CW-1:0]  r_idx;
    logic [CW-1:0]  r_cidx;
    logic           r_pend;
    logic           r_busy;
    logic           r_lock;

    logic [vcrd_pkg::TAG_BITS-1:0] lock_rdata;
    logic [vcrd_pkg::TAG_BITS-1:0] acc_rdata;
    logic [vcrd_pkg::TAG_BITS-1:0] rdata;
    logic [CW-1:0]                 cnt;
    logic                          full;
    logic                          issue;
    vcrd_pkg::t_srch_sts           sts;

    // lock tag and address tag stores, filled in order from slot 0
    vcrd_ram #(.WIDTH(vcrd_pkg::TAG_BITS), .DEPTH(LOCK_ENTRIES)) u_lock_tags (
        .i_clk   (i_clk),
        .i_we    (i_ctl.alloc && i_ctl.is_lock),
        .i_waddr (r_lcnt[LAW-1:0]),
        .i_wdata (i_tag),
        .i_raddr (r_idx[LAW-1:0]),
        .o_rdata (lock_rdata)
    );

    vcrd_ram #(.WIDTH(vcrd_pkg::TAG_BITS), .DEPTH(ACCESS_ENTRIES)) u_acc_tags (
        .i_clk   (i_clk),
        .i_we    (i_ctl.alloc && !i_ctl.is_lock),
        .i_waddr (r_acnt[AAW-1:0]),
        .i_wdata (i_tag),
        .i_raddr (r_idx[AAW-1:0]),
        .o_rdata (acc_rdata)
    );

    // scan compare, one tag per cycle
    always_comb begin
        rdata = r_lock ? lock_rdata : acc_rdata;
        cnt   = r_lock ? CW'(r_lcnt) : CW'(r_acnt);
        full  = r_lock ? (r_lcnt == LCW'(LOCK_ENTRIES)) : (r_acnt == ACW'(ACCESS_ENTRIES));
        sts   = '0;
        o_slot = SW'(cnt);
        issue = 1'b0;
        if (r_busy) begin
            if (r_pend && (rdata == i_tag)) begin
                sts.done = 1'b1;
                sts.hit  = 1'b1;
                o_slot   = SW'(r_cidx);
            end else if (r_idx == cnt) begin
                sts.done = 1'b1;
                sts.full = full;
            end else begin
                issue = 1'b1;
            end
        end
    end

    assign o_sts = sts;

    // scan and fill counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lcnt <= '0;
            r_acnt <= '0;
            r_busy <= 1'b0;
            r_pend <= 1'b0;
            r_idx  <= '0;
            r_lock <= 1'b0;
        end else begin
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_lock <= i_ctl.is_lock;
                r_idx  <= '0;
                r_pend <= 1'b0;
            end else if (sts.done) begin
                r_busy <= 1'b0;
                r_pend <= 1'b0;
            end else if (issue) begin
                r_pend <= 1'b1;
                r_idx  <= r_idx + CW'(1);
            end
            if (i_ctl.alloc) begin
                if (i_ctl.is_lock) begin
                    r_lcnt <= r_lcnt + LCW'(1);
                end else begin
                    r_acnt <= r_acnt + ACW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_cidx <= r_idx;
        end
    end

endmodule

[design/vector_clock_race_detector.sv]
// Vector clock race detector.
// Input channel: i_in_valid / o_in_stall with i_kind, i_thread_id and
// i_target_address. An item is taken when valid is high and stall is low.
// Output channel: o_out_valid / i_out_stall with o_race_detected, o_no_room
// and o_bad_request; exactly one result per item.
// One item is worked at a time. A thread start goes from the check state
// straight to the vector pass; lock and memory events first run the tag
// scan, which reads tags up to and including the match, or every filled
// entry on a miss, and then the vector pass. An acquire of an unknown
// lock or a miss on a full table ends after the scan. The tag scan reads
// one tag a cycle from the tag store, and the vector pass reads and writes
// one clock component a cycle. Bad threads are flagged as bad requests;
// lock address zero and unknown kinds end without a flag; all of these
// skip the scan and the vector pass.
// Reset empties all tables and the thread count at once; no clearing pass.
// A finished result sits in an output register; while the receiver stalls,
// the next item may be accepted and worked, and it waits to deliver until
// the register is taken.
module vector_clock_race_detector #(
    parameter int MAX_THREADS    = vcrd_pkg::MAX_THREADS_DEF,
    parameter int LOCK_ENTRIES   = vcrd_pkg::LOCK_ENTRIES_DEF,
    parameter int ACCESS_ENTRIES = vcrd_pkg::ACCESS_ENTRIES_DEF,
    parameter int CLOCK_BITS     = vcrd_pkg::CLOCK_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [2:0]                    i_kind,
    input  logic [2:0]                    i_thread_id,
    input  logic [vcrd_pkg::TAG_BITS-1:0] i_target_address,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_race_detected,
    output logic                          o_no_room,
    output logic                          o_bad_request
);

    localparam int TW   = $clog2(MAX_THREADS);
    localparam int TCW  = $clog2(MAX_THREADS + 1);
    localparam int LAW  = (LOCK_ENTRIES > 1) ? $clog2(LOCK_ENTRIES) : 1;
    localparam int AAW  = $clog2(ACCESS_ENTRIES);
    localparam int SW   = (LAW > AAW) ? LAW : AAW;
    localparam int TMW  = $clog2(MAX_THREADS * MAX_THREADS);
    localparam int LMW  = $clog2(LOCK_ENTRIES * MAX_THREADS);
    localparam int AMW  = $clog2(ACCESS_ENTRIES * MAX_THREADS);

    vcrd_pkg::t_state r_state, n_state;
    vcrd_pkg::t_op    r_op, n_op;

    logic [2:0]                    r_kind;
    logic [2:0]                    r_tid;
    logic [vcrd_pkg::TAG_BITS-1:0] r_addr;
    logic [TCW-1:0]                r_active, n_active;
    logic [SW-1:0]                 r_slot, n_slot;
    logic [TCW-1:0]                r_j, n_j;
    logic [TW-1:0]                 r_pj, n_pj;
    logic                          r_pv, n_pv;
    logic                          r_race, n_race;
    logic                          r_noroom, n_noroom;
    logic                          r_bad, n_bad;
    logic                          r_out_valid, n_out_valid;
    logic                          r_o_race, r_o_noroom, r_o_bad;
    logic                          load_out;

    vcrd_pkg::t_srch_ctl srch_ctl;
    vcrd_pkg::t_srch_sts srch_sts;
    logic [SW-1:0]       srch_slot;

    logic [TW-1:0]         tid_row;
    logic                  issue;
    logic                  own;
    logic [CLOCK_BITS-1:0] tcd, lcd, rcd, wcd;
    logic                  tc_we, lc_we, rc_we, wc_we;
    logic [CLOCK_BITS-1:0] tc_wd, rc_wd, wc_wd;
    logic [TMW-1:0]        tc_ra, tc_wa;
    logic [LMW-1:0]        lc_ra, lc_wa;
    logic [AMW-1:0]        ac_ra, ac_wa;

    assign tid_row = TW'(r_tid);
    assign issue   = (r_state == vcrd_pkg::ST_VEC) && (r_j < TCW'(MAX_THREADS));
    assign own     = (r_pj == tid_row);

    // tag search unit
    vcrd_search #(
        .LOCK_ENTRIES   (LOCK_ENTRIES),
        .ACCESS_ENTRIES (ACCESS_ENTRIES),
        .SW             (SW)
    ) u_search (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (srch_ctl),
        .i_tag   (r_addr),
        .o_sts   (srch_sts),
        .o_slot  (srch_slot)
    );

    // clock memory addresses: row times thread count plus component
    always_comb begin
        tc_ra = TMW'(tid_row) * TMW'(MAX_THREADS) + TMW'(r_j);
        tc_wa = TMW'(tid_row) * TMW'(MAX_THREADS) + TMW'(r_pj);
        lc_ra = LMW'(r_slot) * LMW'(MAX_THREADS) + LMW'(r_j);
        lc_wa = LMW'(r_slot) * LMW'(MAX_THREADS) + LMW'(r_pj);
        ac_ra = AMW'(r_slot) * AMW'(MAX_THREADS) + AMW'(r_j);
        ac_wa = AMW'(r_slot) * AMW'(MAX_THREADS) + AMW'(r_pj);
    end

    vcrd_ram #(.WIDTH(CLOCK_BITS), .DEPTH(MAX_THREADS * MAX_THREADS)) u_thread_clk (
        .i_clk (i_clk), .i_we (tc_we), .i_waddr (tc_wa), .i_wdata (tc_wd),
        .i_raddr (tc_ra), .o_rdata (tcd)
    );

    vcrd_ram #(.WIDTH(CLOCK_BITS), .DEPTH(LOCK_ENTRIES * MAX_THREADS)) u_lock_clk (
        .i_clk (i_clk), .i_we (lc_we), .i_waddr (lc_wa), .i_wdata (tcd),
        .i_raddr (lc_ra), .o_rdata (lcd)
    );

    vcrd_ram #(.WIDTH(CLOCK_BITS), .DEPTH(ACCESS_ENTRIES * MAX_THREADS)) u_read_clk (
        .i_clk (i_clk), .i_we (rc_we), .i_waddr (ac_wa), .i_wdata (rc_wd),
        .i_raddr (ac_ra), .o_rdata (rcd)
    );

    vcrd_ram #(.WIDTH(CLOCK_BITS), .DEPTH(ACCESS_ENTRIES * MAX_THREADS)) u_write_clk (
        .i_clk (i_clk), .i_we (wc_we), .i_waddr (ac_wa), .i_wdata (wc_wd),
        .i_raddr (ac_ra), .o_rdata (wcd)
    );

    // per-component read-modify-write of the clock vectors
    always_comb begin
        tc_we = 1'b0;
        lc_we = 1'b0;
        rc_we = 1'b0;
        wc_we = 1'b0;
        tc_wd = tcd;
        rc_wd = tcd;
        wc_wd = tcd;
        n_race = r_race;
        if (r_pv) begin
            case (r_op)
                vcrd_pkg::OP_START: begin
                    tc_we = 1'b1;
                    tc_wd = own ? CLOCK_BITS'(1) : '0;
                end
                vcrd_pkg::OP_ACQ: begin
                    tc_we = 1'b1;
                    tc_wd = (lcd > tcd) ? lcd : tcd;
                end
                vcrd_pkg::OP_REL: begin
                    lc_we = 1'b1;
                    tc_we = own;
                    tc_wd = (tcd == '1) ? tcd : tcd + CLOCK_BITS'(1);
                end
                vcrd_pkg::OP_RD: begin
                    rc_we = own;
                    if (wcd > tcd) begin
                        n_race = 1'b1;
                    end
                end
                vcrd_pkg::OP_WR: begin
                    wc_we = own;
                    if ((!own && (wcd > tcd)) || (rcd > tcd)) begin
                        n_race = 1'b1;
                    end
                end
                vcrd_pkg::OP_RD_NEW: begin
                    rc_we = 1'b1;
                    wc_we = 1'b1;
                    rc_wd = own ? tcd : '0;
                    wc_wd = '0;
                end
                vcrd_pkg::OP_WR_NEW: begin
                    rc_we = 1'b1;
                    wc_we = 1'b1;
                    rc_wd = '0;
                    wc_wd = own ? tcd : '0;
                end
                default: begin
                    n_race = r_race;
                end
            endcase
        end
    end

    // sequencer: next state and control
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_active    = r_active;
        n_slot      = r_slot;
        n_j         = r_j;
        n_pj        = r_pj;
        n_pv        = 1'b0;
        n_noroom    = r_noroom;
        n_bad       = r_bad;
        srch_ctl    = '0;
        load_out    = 1'b0;
        n_out_valid = r_out_valid && i_out_stall;
        o_in_stall  = (r_state != vcrd_pkg::ST_IDLE);
        case (r_state)
            vcrd_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = vcrd_pkg::ST_CHECK;
                end
            end
            vcrd_pkg::ST_CHECK: begin
                n_j     = '0;
                n_state = vcrd_pkg::ST_DONE;
                if (r_kind == vcrd_pkg::KIND_START) begin
                    if ((32'(r_tid) != 32'(r_active)) || (32'(r_tid) >= MAX_THREADS)) begin
                        n_bad = 1'b1;
                    end else begin
                        n_active = r_active + TCW'(1);
                        n_op     = vcrd_pkg::OP_START;
                        n_state  = vcrd_pkg::ST_VEC;
                    end
                end else if (r_kind inside {vcrd_pkg::KIND_ACQUIRE, vcrd_pkg::KIND_RELEASE,
                                            vcrd_pkg::KIND_READ, vcrd_pkg::KIND_WRITE}) begin
                    if (32'(r_tid) >= 32'(r_active)) begin
                        n_bad = 1'b1;
                    end else if (r_kind inside {vcrd_pkg::KIND_ACQUIRE, vcrd_pkg::KIND_RELEASE}
                                 && (r_addr == '0)) begin
                        n_state = vcrd_pkg::ST_DONE;
                    end else begin
                        srch_ctl.start   = 1'b1;
                        srch_ctl.is_lock = r_kind inside {vcrd_pkg::KIND_ACQUIRE,
                                                          vcrd_pkg::KIND_RELEASE};
                        n_state          = vcrd_pkg::ST_SEARCH;
                    end
                end
            end
            vcrd_pkg::ST_SEARCH: begin
                srch_ctl.is_lock = r_kind inside {vcrd_pkg::KIND_ACQUIRE, vcrd_pkg::KIND_RELEASE};
                if (srch_sts.done) begin
                    n_slot  = srch_slot;
                    n_state = vcrd_pkg::ST_VEC;
                    case (r_kind)
                        vcrd_pkg::KIND_ACQUIRE: n_op = vcrd_pkg::OP_ACQ;
                        vcrd_pkg::KIND_RELEASE: n_op = vcrd_pkg::OP_REL;
                        vcrd_pkg::KIND_READ:
                            n_op = srch_sts.hit ? vcrd_pkg::OP_RD : vcrd_pkg::OP_RD_NEW;
                        default:
                            n_op = srch_sts.hit ? vcrd_pkg::OP_WR : vcrd_pkg::OP_WR_NEW;
                    endcase
                    if (!srch_sts.hit) begin
                        if (r_kind == vcrd_pkg::KIND_ACQUIRE) begin
                            n_state = vcrd_pkg::ST_DONE;
                        end else if (srch_sts.full) begin
                            n_noroom = 1'b1;
                            n_state  = vcrd_pkg::ST_DONE;
                        end else begin
                            srch_ctl.alloc = 1'b1;
                        end
                    end
                end
            end
            vcrd_pkg::ST_VEC: begin
                n_pv = issue;
                n_pj = TW'(r_j);
                if (issue) begin
                    n_j = r_j + TCW'(1);
                end else if (!r_pv) begin
                    n_state = vcrd_pkg::ST_DONE;
                end
            end
            vcrd_pkg::ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    load_out    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = vcrd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = vcrd_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= vcrd_pkg::ST_IDLE;
            r_active    <= '0;
            r_out_valid <= 1'b0;
            r_pv        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
            r_pv        <= n_pv;
        end
    end

    // item and working registers
    always_ff @(posedge i_clk) begin
        if ((r_state == vcrd_pkg::ST_IDLE) && i_in_valid) begin
            r_kind   <= i_kind;
            r_tid    <= i_thread_id;
            r_addr   <= i_target_address;
            r_race   <= 1'b0;
            r_noroom <= 1'b0;
            r_bad    <= 1'b0;
        end else begin
            r_race   <= n_race;
            r_noroom <= n_noroom;
            r_bad    <= n_bad;
        end
        r_op   <= n_op;
        r_slot <= n_slot;
        r_j    <= n_j;
        r_pj   <= n_pj;
        if (load_out) begin
            r_o_race   <= r_race;
            r_o_noroom <= r_noroom;
            r_o_bad    <= r_bad;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_race_detected = r_o_race;
    assign o_no_room       = r_o_noroom;
    assign o_bad_request   = r_o_bad;

endmodule

[design/vcrd_checker.sv]
`include "assert_macros.svh"

module vcrd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_race_detected,
    input logic        o_no_room,
    input logic        o_bad_request
);

    // a stalled result stays offered
    `VCRD_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid, "result dropped")

    // one item at a time: busy right after an accept
    `VCRD_ASSERT_NEXT(a_busy, i_in_valid && !o_in_stall, o_in_stall, "accepted while busy")

    // at most one flag per result
    `VCRD_ASSERT_NOW(a_flags, o_out_valid,
        $onehot0({o_race_detected, o_no_room, o_bad_request}), "conflicting flags")

    // reset leaves no result pending
    `VCRD_ASSERT_RST(a_rst, !i_rst_n, !o_out_valid, "result after reset")

endmodule

bind vector_clock_race_detector vcrd_checker u_vcrd_checker (.*);

[tb/vector_clock_race_detector_test.sv]
`timescale 1ns / 1ps

module vector_clock_race_detector_test;

    localparam int NTHR       = vcrd_pkg::MAX_THREADS_DEF;
    localparam int NLOCK      = vcrd_pkg::LOCK_ENTRIES_DEF;
    localparam int NACC       = vcrd_pkg::ACCESS_ENTRIES_DEF;
    localparam int CBITS      = vcrd_pkg::CLOCK_BITS_DEF;
    localparam int RAND_ITEMS = 1850;
    localparam int CYCLE_CAP  = 4000000;

    // event kinds
    localparam logic [2:0] K_START    = vcrd_pkg::KIND_START;
    localparam logic [2:0] K_ACQUIRE  = vcrd_pkg::KIND_ACQUIRE;
    localparam logic [2:0] K_RELEASE  = vcrd_pkg::KIND_RELEASE;
    localparam logic [2:0] K_READ     = vcrd_pkg::KIND_READ;
    localparam logic [2:0] K_WRITE    = vcrd_pkg::KIND_WRITE;
    localparam logic [2:0] K_UNDEF_LO = 3'd5;
    localparam logic [2:0] K_UNDEF_MI = 3'd6;
    localparam logic [2:0] K_UNDEF_HI = 3'd7;

    typedef logic [CBITS-1:0] t_clk;
    typedef t_clk t_vec [NTHR];
    typedef struct packed {
        logic race;
        logic room;
        logic bad;
    } t_flags;
    typedef struct {
        logic [2:0]  kind;
        logic [2:0]  tid;
        logic [63:0] addr;
        logic        fixed;
        t_flags      res;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [2:0]  i_kind;
    logic [2:0]  i_thread_id;
    logic [63:0] i_target_address;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_race_detected;
    logic        o_no_room;
    logic        o_bad_request;

    vector_clock_race_detector dut (.*);

    // shadow state of the detector
    int          live_threads;
    t_vec        thr_vec [NTHR];
    logic [63:0] lock_tag [NLOCK];
    logic        lock_used [NLOCK];
    t_vec        lock_vec [NLOCK];
    logic [63:0] acc_tag [NACC];
    logic        acc_used [NACC];
    t_vec        rd_vec [NACC];
    t_vec        wr_vec [NACC];

    t_flags      flags_due [$];
    t_flags      fixed_due [$];
    logic        fixed_on [$];
    int          n_fail;
    int          n_res;
    int          n_race;
    int          n_room;
    int          n_bad;
    longint      cycles;
    logic [63:0] addr_pool [8];
    logic [63:0] lock_pool [4];

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("vector_clock_race_detector test failed");
            $finish;
        end
    end

    function automatic logic vec_leq(t_vec a, t_vec b);
        for (int i = 0; i < NTHR; i++)
            if (a[i] > b[i]) return 1'b0;
        return 1'b1;
    endfunction

    // computes the flags of one event and updates the shadow state
    function automatic t_flags detect_race(logic [2:0] kind, logic [2:0] tid,
                                           logic [63:0] addr);
        t_flags f;
        int hit;
        int spare;
        f = '0;
        hit = -1;
        spare = -1;
        if (kind == K_START) begin
            if (tid != live_threads || tid >= NTHR) f.bad = 1;
            else begin
                for (int i = 0; i < NTHR; i++) thr_vec[tid][i] = '0;
                thr_vec[tid][tid] = 1;
                live_threads++;
            end
        end else if (kind <= K_WRITE) begin
            if (tid >= live_threads) f.bad = 1;
            else if ((kind == K_ACQUIRE || kind == K_RELEASE) && addr != 0) begin
                for (int i = 0; i < NLOCK; i++) begin
                    if (lock_used[i]) begin
                        if (lock_tag[i] == addr && hit < 0) hit = i;
                    end else if (spare < 0) spare = i;
                end
                if (kind == K_ACQUIRE) begin
                    if (hit >= 0)
                        for (int i = 0; i < NTHR; i++)
                            if (lock_vec[hit][i] > thr_vec[tid][i])
                                thr_vec[tid][i] = lock_vec[hit][i];
                end else if (hit < 0 && spare < 0) f.room = 1;
                else begin
                    if (hit < 0) begin
                        hit = spare;
                        lock_used[hit] = 1;
                        lock_tag[hit] = addr;
                    end
                    lock_vec[hit] = thr_vec[tid];
                    if (thr_vec[tid][tid] != '1) thr_vec[tid][tid]++;
                end
            end else if (kind == K_READ || kind == K_WRITE) begin
                for (int i = 0; i < NACC; i++) begin
                    if (acc_used[i]) begin
                        if (acc_tag[i] == addr && hit < 0) hit = i;
                    end else if (spare < 0) spare = i;
                end
                if (hit < 0) begin
                    if (spare < 0) f.room = 1;
                    else begin
                        acc_used[spare] = 1;
                        acc_tag[spare] = addr;
                        for (int i = 0; i < NTHR; i++) begin
                            rd_vec[spare][i] = '0;
                            wr_vec[spare][i] = '0;
                        end
                        if (kind == K_WRITE) wr_vec[spare][tid] = thr_vec[tid][tid];
                        else rd_vec[spare][tid] = thr_vec[tid][tid];
                    end
                end else if (kind == K_WRITE) begin
                    wr_vec[hit][tid] = thr_vec[tid][tid];
                    f.race = !vec_leq(wr_vec[hit], thr_vec[tid]) ||
                             !vec_leq(rd_vec[hit], thr_vec[tid]);
                end else begin
                    rd_vec[hit][tid] = thr_vec[tid][tid];
                    f.race = !vec_leq(wr_vec[hit], thr_vec[tid]);
                end
            end
        end
        return f;
    endfunction

    // drives one item after a random gap, queues its expected flags
    task automatic send_item(logic [2:0] kind, logic [2:0] tid, logic [63:0] addr,
                             logic fixed, t_flags res);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_kind <= kind;
        i_thread_id <= tid;
        i_target_address <= addr;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        flags_due = {flags_due, detect_race(kind, tid, addr)};
        fixed_due = {fixed_due, res};
        fixed_on = {fixed_on, fixed};
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_flags got;
        t_flags want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_race_detected, o_no_room, o_bad_request};
            n_res++;
            n_race += got.race;
            n_room += got.room;
            n_bad += got.bad;
            if (flags_due.size() == 0) begin
                n_fail++;
                if (n_fail <= 10) $display("unexpected result %b", got);
            end else begin
                want = flags_due.pop_front();
                if (fixed_on.pop_front() && fixed_due[0] != want) begin
                    n_fail++;
                    if (n_fail <= 10) $display("table row %b disagrees with %b",
                                               fixed_due[0], want);
                end
                void'(fixed_due.pop_front());
                if (got != want) begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("flags mismatch: race/room/bad exp %b got %b", want, got);
                end
            end
        end
    end

    // receiver: draws a random hold count per result and stalls while it is nonzero
    initial begin
        int hold;
        hold = $urandom_range(0, 3);
        i_out_stall = (hold != 0);
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall) hold = $urandom_range(0, 3);
            else if (o_out_valid && (hold > 0)) hold--;
            i_out_stall <= (hold != 0);
        end
    end

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (flags_due.size() != 0) @(posedge i_clk);
        repeat (4 + NACC + NTHR + 10) @(posedge i_clk);
    endtask

    initial begin
        t_row rows [$];
        logic [2:0]  k;
        logic [2:0]  t;
        logic [63:0] a;
        int          r;
        cycles = 0;
        n_fail = 0;
        n_res = 0;
        n_race = 0;
        n_room = 0;
        n_bad = 0;
        live_threads = 0;
        foreach (lock_used[i]) lock_used[i] = 0;
        foreach (acc_used[i]) acc_used[i] = 0;
        foreach (thr_vec[i, j]) thr_vec[i][j] = '0;
        i_rst_n = 0;
        i_in_valid = 0;
        i_kind = K_START;
        i_thread_id = 0;
        i_target_address = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed table: fixed flags where obvious, predictor elsewhere
        rows = '{
            '{K_READ,     3'd0, 64'h10,  1'b1, 3'b001},
            '{K_START,    3'd1, 64'h0,   1'b1, 3'b001},
            '{K_START,    3'd0, '1,      1'b1, 3'b000},
            '{K_START,    3'd1, 64'h0,   1'b1, 3'b000},
            '{K_WRITE,    3'd2, 64'h10,  1'b1, 3'b001},
            '{K_UNDEF_MI, 3'd0, 64'h10,  1'b1, 3'b000},
            '{K_UNDEF_HI, 3'd7, '1,      1'b1, 3'b000},
            '{K_UNDEF_LO, 3'd0, 64'h5,   1'b1, 3'b000},
            '{K_ACQUIRE,  3'd0, 64'h0,   1'b1, 3'b000},
            '{K_RELEASE,  3'd0, 64'h0,   1'b1, 3'b000},
            '{K_ACQUIRE,  3'd0, 64'hABC, 1'b1, 3'b000},
            '{K_WRITE,    3'd0, 64'h0,   1'b1, 3'b000},
            '{K_WRITE,    3'd1, 64'h0,   1'b0, 3'b000},
            '{K_READ,     3'd0, '1,      1'b1, 3'b000},
            '{K_WRITE,    3'd1, '1,      1'b0, 3'b000},
            '{K_RELEASE,  3'd0, '1,      1'b0, 3'b000},
            '{K_ACQUIRE,  3'd1, '1,      1'b0, 3'b000},
            '{K_WRITE,    3'd1, 64'h0,   1'b0, 3'b000},
            '{K_READ,     3'd0, 64'h0,   1'b0, 3'b000}
        };
        foreach (rows[i]) send_item(rows[i].kind, rows[i].tid, rows[i].addr,
                                    rows[i].fixed, rows[i].res);
        for (int i = 2; i < 9; i++) send_item(K_START, i[2:0], '0, 1'b0, '0);

        // fill the lock table and overflow it
        for (int i = 0; i <= NLOCK; i++)
            send_item(K_RELEASE, 3'(i), 64'h1000 + 64'(i), 1'b0, '0);
        wait_drain();

        // random part: well-formed traffic over small address pools
        foreach (addr_pool[i]) addr_pool[i] = {$urandom, $urandom};
        foreach (lock_pool[i]) lock_pool[i] = 64'h1000 + 64'($urandom_range(0, NLOCK + 2));
        for (int n = 0; n < RAND_ITEMS; n++) begin
            r = $urandom_range(0, 99);
            t = 3'($urandom_range(0, 7));
            if (r < 30) begin
                k = K_READ;
                a = addr_pool[$urandom_range(0, 7)];
            end else if (r < 60) begin
                k = K_WRITE;
                a = addr_pool[$urandom_range(0, 7)];
            end else if (r < 72) begin
                k = K_ACQUIRE;
                a = lock_pool[$urandom_range(0, 3)];
            end else if (r < 84) begin
                k = K_RELEASE;
                a = lock_pool[$urandom_range(0, 3)];
            end else begin
                // noise: fresh addresses fill the table, odd kinds
                k = 3'($urandom_range(0, 7));
                a = {$urandom, $urandom};
            end
            if (n % 300 == 0) addr_pool[$urandom_range(0, 7)] = {$urandom, $urandom};
            send_item(k, t, a, 1'b0, '0);
            if (n == RAND_ITEMS / 2) wait_drain();
        end

        wait_drain();
        $display("covered %0d results: %0d races, %0d table-full, %0d rejected events",
                 n_res, n_race, n_room, n_bad);
        $display("directed table, lock table overflow and random traffic with stalls done");
        if (n_fail == 0 && flags_due.size() == 0)
            $display("vector_clock_race_detector test passed");
        else begin
            $display("%0d mismatches, %0d results outstanding", n_fail, flags_due.size());
            $display("vector_clock_race_detector test failed");
        end
        $finish;
    end
endmodule
